FILE: sv/border_connected_region_fill_assert.svh
// assertion macros for the region fill block
`ifndef BORDER_CONNECTED_REGION_FILL_ASSERT_SVH
`define BORDER_CONNECTED_REGION_FILL_ASSERT_SVH

// same-cycle implication
`define BCRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcrf assertion failed");

// next-cycle implication
`define BCRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcrf assertion failed");

`endif

FILE: sv/bcrf_pkg.sv
`timescale 1ns / 1ps
package bcrf_pkg;
	localparam int ROW_W = 32;
	localparam int CNT_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd1;

	typedef logic [ROW_W-1:0] row_t;

	typedef struct packed {
		logic init;
		row_t open;
		row_t cur;
		row_t nbr;
		row_t seed;
		row_t mask;
	} row_in_t;

	typedef struct packed {
		row_t nxt;
		logic changed;
	} row_out_t;
endpackage

FILE: sv/bcrf_in_if.sv
`timescale 1ns / 1ps
interface bcrf_in_if
	import bcrf_pkg::*;
();
	logic valid;
	logic ready;
	row_t row_cells;

	modport source (output valid, output row_cells, input ready);
	modport sink (input valid, input row_cells, output ready);
endinterface

FILE: sv/bcrf_out_if.sv
`timescale 1ns / 1ps
interface bcrf_out_if
	import bcrf_pkg::*;
();
	logic valid;
	logic ready;
	row_t out_cells;
	logic last_row;

	modport source (output valid, output out_cells, output last_row, input ready);
	modport sink (input valid, input out_cells, input last_row, output ready);
endinterface

FILE: sv/border_connected_region_fill.sv
// rows load one word per cycle, only in the load state; fill begins after the last row
// fill: sweeps alternate down and up over the reach memory, each row read then updated,
// ending after a down and an up sweep without change; sweeps >= 3
// results: each row via reach memory read port and output register, held until taken
// reset: grid size 32 x 32, row count and sequencer cleared; memories are not cleared
`timescale 1ns / 1ps
module border_connected_region_fill
	import bcrf_pkg::*;
#(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	bcrf_in_if.sink              in_ch,
	bcrf_out_if.source           out_ch
);
	`include "border_connected_region_fill_assert.svh"

	localparam int ROW_LIM = (MAX_ROWS > ROW_W) ? ROW_W : MAX_ROWS;
	localparam int COL_LIM = (MAX_COLS > ROW_W) ? ROW_W : MAX_COLS;
	localparam int AW = (ROW_LIM > 1) ? $clog2(ROW_LIM) : 1;
	localparam int DEPTH = 1 << AW;

	localparam logic [2:0] S_LOAD      = 3'd0;
	localparam logic [2:0] S_RD        = 3'd1;
	localparam logic [2:0] S_UPD       = 3'd2;
	localparam logic [2:0] S_EMIT_RD   = 3'd3;
	localparam logic [2:0] S_EMIT_LD   = 3'd4;
	localparam logic [2:0] S_EMIT_WAIT = 3'd5;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] grid_rows_q, grid_cols_q;
	logic [CNT_W-1:0] loaded_q, idx_q;
	logic             dir_q, first_q, chg_q, quiet_q;
	row_t             prev_q;
	logic             out_valid_q, out_last_q;
	row_t             out_cells_q;

	logic [CNT_W-1:0] rows_eff, cols_eff, load_idx, rows_m1;
	row_t             mask, edge_bits, open_rd, reach_rd;
	logic             in_acc, out_acc, sweep_end, sweep_chg;
	row_in_t          unit_in;
	row_out_t         unit_out;

	always_comb begin
		rows_eff = grid_rows_q;
		if (rows_eff == '0) rows_eff = CNT_W'(1);
		if (rows_eff > CNT_W'(ROW_LIM)) rows_eff = CNT_W'(ROW_LIM);
		cols_eff = grid_cols_q;
		if (cols_eff == '0) cols_eff = CNT_W'(1);
		if (cols_eff > CNT_W'(COL_LIM)) cols_eff = CNT_W'(COL_LIM);
		rows_m1 = rows_eff - CNT_W'(1);
		mask = (cols_eff >= CNT_W'(ROW_W)) ? '1
			: ROW_W'(({{ROW_W{1'b0}}, 1'b1} << cols_eff) - {{ROW_W{1'b0}}, 1'b1});
		edge_bits = ROW_W'(1) | (ROW_W'(1) << (cols_eff - CNT_W'(1)));
		load_idx = (loaded_q >= rows_eff) ? rows_m1 : loaded_q;
	end

	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign in_ch.ready = (state_q == S_LOAD);
	assign out_ch.valid = out_valid_q;
	assign out_ch.out_cells = out_cells_q;
	assign out_ch.last_row = out_last_q;

	bcrf_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_open_ram (
		.clk   (clk),
		.we    (in_acc),
		.waddr (load_idx[AW-1:0]),
		.wdata (in_ch.row_cells & mask),
		.raddr (idx_q[AW-1:0]),
		.rdata (open_rd)
	);

	bcrf_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_reach_ram (
		.clk   (clk),
		.we    (state_q == S_UPD),
		.waddr (idx_q[AW-1:0]),
		.wdata (unit_out.nxt),
		.raddr (idx_q[AW-1:0]),
		.rdata (reach_rd)
	);

	always_comb begin
		unit_in.init = first_q;
		unit_in.open = open_rd;
		unit_in.cur = reach_rd;
		unit_in.nbr = prev_q;
		unit_in.seed = (idx_q == '0 || idx_q == rows_m1) ? mask : edge_bits;
		unit_in.mask = mask;
	end

	bcrf_row_unit u_row_unit (
		.op  (unit_in),
		.res (unit_out)
	);

	assign sweep_end = dir_q ? (idx_q == '0) : (idx_q == rows_m1);
	assign sweep_chg = chg_q || unit_out.changed || first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= CFG_W'(32);
			grid_cols_q <= CFG_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_GRID_ROWS: grid_rows_q <= cfg_data;
				CFG_GRID_COLS: grid_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			loaded_q <= '0;
			idx_q <= '0;
			dir_q <= 1'b0;
			first_q <= 1'b0;
			chg_q <= 1'b0;
			quiet_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (load_idx + CNT_W'(1) == rows_eff) begin
							loaded_q <= '0;
							idx_q <= '0;
							dir_q <= 1'b0;
							first_q <= 1'b1;
							chg_q <= 1'b0;
							quiet_q <= 1'b0;
							state_q <= S_RD;
						end else begin
							loaded_q <= load_idx + CNT_W'(1);
						end
					end
				end
				S_RD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (!sweep_end) begin
						chg_q <= chg_q || unit_out.changed;
						idx_q <= dir_q ? idx_q - CNT_W'(1) : idx_q + CNT_W'(1);
						state_q <= S_RD;
					end else if (!sweep_chg && quiet_q) begin
						idx_q <= '0;
						state_q <= S_EMIT_RD;
					end else begin
						quiet_q <= !sweep_chg;
						dir_q <= !dir_q;
						first_q <= 1'b0;
						chg_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					out_valid_q <= 1'b1;
					out_last_q <= (idx_q == rows_m1);
					state_q <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							idx_q <= '0;
							state_q <= S_LOAD;
						end else begin
							idx_q <= idx_q + CNT_W'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			prev_q <= sweep_end ? '0 : unit_out.nxt;
		end else if (state_q == S_LOAD) begin
			prev_q <= '0;
		end
		if (state_q == S_EMIT_LD) begin
			out_cells_q <= reach_rd & mask;
		end
	end

	`BCRF_ASSERT_NXT(a_last_frees_input, clk, arst_n, out_acc && out_ch.last_row, in_ch.ready)
	`BCRF_ASSERT_IMP(a_no_overlap, clk, arst_n, out_ch.valid, !in_ch.ready)
	`BCRF_ASSERT_IMP(a_sweep_in_grid, clk, arst_n, state_q == S_RD || state_q == S_UPD, idx_q < rows_eff)
endmodule

FILE: sv/bcrf_ram.sv
`timescale 1ns / 1ps
module bcrf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: sv/bcrf_row_unit.sv
`timescale 1ns / 1ps
module bcrf_row_unit
	import bcrf_pkg::*;
(
	input  row_in_t  op,
	output row_out_t res
);
	function automatic row_t rev(input row_t v);
		row_t r;
		for (int i = 0; i < ROW_W; i++) begin
			r[i] = v[ROW_W-1-i];
		end
		return r;
	endfunction

	// seeds plus every open bit that a carry from a seed reaches
	function automatic row_t run_fill(input row_t ov, input row_t sv);
		row_t c;
		c = (ov + sv) ^ ov ^ sv;
		return ov & (sv | c);
	endfunction

	row_t o, base, s, up, ro, rs, dn, nxt;

	always_comb begin
		o = op.open & op.mask;
		base = op.init ? (o & op.seed) : op.cur;
		s = (base | op.nbr) & o;
		// carry runs through each open run from its seeds toward the msb
		up = run_fill(o, s);
		ro = rev(o);
		rs = rev(s);
		dn = rev(run_fill(ro, rs));
		nxt = up | dn;
		res.nxt = nxt;
		res.changed = (nxt != op.cur);
	end
endmodule
